### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/xo256ss_pkg.sv
// ----------------------------------------------------------------------------
// xo256ss_pkg
// Types, constants and helpers shared by the xoshiro256** generator.
// ----------------------------------------------------------------------------
package xo256ss_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_ONE = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_TWO = 64'h94d049bb133111eb;

    // Config register indexes
    localparam logic [2:0] REG_OUT_MULT_A   = 3'd0;
    localparam logic [2:0] REG_OUT_MULT_B   = 3'd1;
    localparam logic [2:0] REG_OUT_ROTATE   = 3'd2;
    localparam logic [2:0] REG_STATE_ROTATE = 3'd3;
    localparam logic [2:0] REG_STATE_SHIFT  = 3'd4;

    // Config reset values
    localparam logic [63:0] RST_OUT_MULT_A   = 64'd5;
    localparam logic [63:0] RST_OUT_MULT_B   = 64'd9;
    localparam logic [5:0]  RST_OUT_ROTATE   = 6'd7;
    localparam logic [5:0]  RST_STATE_ROTATE = 6'd45;
    localparam logic [5:0]  RST_STATE_SHIFT  = 6'd17;

    // Datapath operations
    localparam logic [3:0] DP_NOP          = 4'd0;
    localparam logic [3:0] DP_SEED_ONE     = 4'd1;
    localparam logic [3:0] DP_SEED_LOAD    = 4'd2;
    localparam logic [3:0] DP_MIX_START    = 4'd3;
    localparam logic [3:0] DP_MIX_MID      = 4'd4;
    localparam logic [3:0] DP_MIX_END      = 4'd5;
    localparam logic [3:0] DP_SEED_FIX     = 4'd6;
    localparam logic [3:0] DP_GEN_START    = 4'd7;
    localparam logic [3:0] DP_GEN_SCRAMBLE = 4'd8;
    localparam logic [3:0] DP_OUT_GEN      = 4'd9;
    localparam logic [3:0] DP_OUT_ZERO     = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
    } xo_cmd_t;

    typedef struct packed {
        logic mul_done;
    } xo_stat_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] amt);
        logic [127:0] t;
        t = {v, v} << amt;
        return t[127:64];
    endfunction

endpackage

### rtl/core/xoshiro256ss_generator_unit.sv
// Generate: two 64-bit products in a row from accepted transfer to result.
// Reseed: eight 64-bit products for four splitmix64 words.
// Each 64-bit product goes through the one shared 32x32 multiplier.
// One item at a time: a new request is taken only once the last result is in the output register.
// After reset the unit seeds itself with one (s_ready low);
// config writes are taken at any time, reset restores the default registers.
// ----------------------------------------------------------------------------
// xoshiro256ss_generator_unit
// Xoshiro256** generator with configurable scrambler and state update.
// ----------------------------------------------------------------------------
module xoshiro256ss_generator_unit
    import xo256ss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [63:0] s_seed_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_random_value,
    output logic [63:0] m_generated_count
);

    xo_cmd_t  cmd;
    xo_stat_t stat;

    // Controller: owns the handshake and steps the datapath one op per cycle, NOP while it waits.
    // A finished result waits in its state until the output register is free,
    // and while it waits s_ready stays low, so no new transfer is accepted.
    xo256ss_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: state words, count, config, iterative multiplier, output register.
    // The seed value is read straight from the port in the accepting cycle.
    xo256ss_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .seed_value      (s_seed_value),
        .stat            (stat),
        .random_value    (m_random_value),
        .generated_count (m_generated_count)
    );

endmodule

### rtl/core/xo256ss_mul.sv
// ----------------------------------------------------------------------------
// xo256ss_mul
// 64x64 multiply modulo 2^64 on one shared 32x32 multiplier, four steps.
// ----------------------------------------------------------------------------
module xo256ss_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic [63:0] part_reg, part_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] mx, my;

    // Step 0: aL*bL, step 1: aL*bH, step 2: aH*bL; only low halves of cross terms count.
    always_comb begin
        case (step_reg)
            2'd0: begin
                mx = opa_reg[31:0];
                my = opb_reg[31:0];
            end
            2'd1: begin
                mx = opa_reg[31:0];
                my = opb_reg[63:32];
            end
            default: begin
                mx = opa_reg[63:32];
                my = opb_reg[31:0];
            end
        endcase
    end

    always_comb begin
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        part_next = part_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            opa_next  = op_a;
            opb_next  = op_b;
            step_next = 2'd0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            part_next = {32'd0, mx} * {32'd0, my};
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = part_reg;
                default: acc_next = {acc_reg[63:32] + part_reg[31:0], acc_reg[31:0]};
            endcase
            if (step_reg == 2'd3) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        part_reg <= part_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/core/xo256ss_datapath.sv
// ----------------------------------------------------------------------------
// xo256ss_datapath
// State words, count, config registers, seed mixer and output register.
// ----------------------------------------------------------------------------
module xo256ss_datapath
    import xo256ss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  xo_cmd_t     cmd,
    input  logic [63:0] seed_value,
    output xo_stat_t    stat,
    output logic [63:0] random_value,
    output logic [63:0] generated_count
);

    logic [63:0] mult_a_reg, mult_b_reg;
    logic [5:0]  out_rot_reg, st_rot_reg, st_shift_reg;

    logic [63:0] w_reg [4];
    logic [63:0] w_next [4];
    logic [63:0] cnt_reg, cnt_next;
    logic [63:0] sacc_reg, sacc_next;
    logic [63:0] rnd_reg, rnd_next;
    logic [63:0] ocnt_reg, ocnt_next;

    logic        mul_start;
    logic [63:0] mul_a, mul_b, prod;
    logic        mul_done;
    logic [63:0] mix_sum, cnt_inc;
    logic [63:0] t2, t3;

    xo256ss_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_a_reg   <= RST_OUT_MULT_A;
            mult_b_reg   <= RST_OUT_MULT_B;
            out_rot_reg  <= RST_OUT_ROTATE;
            st_rot_reg   <= RST_STATE_ROTATE;
            st_shift_reg <= RST_STATE_SHIFT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OUT_MULT_A:   mult_a_reg   <= cfg_wdata;
                REG_OUT_MULT_B:   mult_b_reg   <= cfg_wdata;
                REG_OUT_ROTATE:   out_rot_reg  <= cfg_wdata[5:0];
                REG_STATE_ROTATE: st_rot_reg   <= cfg_wdata[5:0];
                REG_STATE_SHIFT:  st_shift_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign mix_sum = sacc_reg + GOLDEN_STEP;
    assign cnt_inc = cnt_reg + 64'd1;
    assign t2      = w_reg[2] ^ w_reg[0];
    assign t3      = w_reg[3] ^ w_reg[1];

    always_comb begin
        w_next    = w_reg;
        cnt_next  = cnt_reg;
        sacc_next = sacc_reg;
        rnd_next  = rnd_reg;
        ocnt_next = ocnt_reg;
        mul_start = 1'b0;
        mul_a     = w_reg[1];
        mul_b     = mult_a_reg;
        case (cmd.op)
            DP_SEED_ONE: sacc_next = 64'd1;
            DP_SEED_LOAD: sacc_next = (seed_value == 64'd0) ? 64'd1 : seed_value;
            DP_MIX_START: begin
                sacc_next = mix_sum;
                mul_start = 1'b1;
                mul_a     = mix_sum ^ (mix_sum >> 30);
                mul_b     = MIX_MUL_ONE;
            end
            DP_MIX_MID: begin
                mul_start = 1'b1;
                mul_a     = prod ^ (prod >> 27);
                mul_b     = MIX_MUL_TWO;
            end
            DP_MIX_END: w_next[cmd.idx] = prod ^ (prod >> 31);
            DP_SEED_FIX: begin
                if ((w_reg[0] | w_reg[1] | w_reg[2] | w_reg[3]) == 64'd0) begin
                    w_next[0] = 64'd1;
                end
                cnt_next = 64'd0;
            end
            DP_GEN_START: begin
                mul_start = 1'b1;
                mul_a     = w_reg[1];
                mul_b     = mult_a_reg;
            end
            DP_GEN_SCRAMBLE: begin
                mul_start = 1'b1;
                mul_a     = rotl64(prod, out_rot_reg);
                mul_b     = mult_b_reg;
            end
            DP_OUT_GEN: begin
                rnd_next  = prod;
                ocnt_next = cnt_inc;
                cnt_next  = cnt_inc;
                w_next[0] = w_reg[0] ^ t3;
                w_next[1] = w_reg[1] ^ t2;
                w_next[2] = t2 ^ (w_reg[1] << st_shift_reg);
                w_next[3] = rotl64(t3, st_rot_reg);
            end
            DP_OUT_ZERO: begin
                rnd_next  = 64'd0;
                ocnt_next = 64'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        w_reg    <= w_next;
        cnt_reg  <= cnt_next;
        sacc_reg <= sacc_next;
        rnd_reg  <= rnd_next;
        ocnt_reg <= ocnt_next;
    end

    assign stat.mul_done   = mul_done;
    assign random_value    = rnd_reg;
    assign generated_count = ocnt_reg;

endmodule

### rtl/core/xo256ss_ctrl.sv
// ----------------------------------------------------------------------------
// xo256ss_ctrl
// Sequencer for generate, reseed and the power-up seeding pass.
// ----------------------------------------------------------------------------
module xo256ss_ctrl
    import xo256ss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_req_type,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  xo_stat_t stat,
    output xo_cmd_t  cmd
);

    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_GEN_WAIT1 = 4'd2;
    localparam logic [3:0] ST_GEN_WAIT2 = 4'd3;
    localparam logic [3:0] ST_GEN_OUT   = 4'd4;
    localparam logic [3:0] ST_MIX_A     = 4'd5;
    localparam logic [3:0] ST_MIX_B     = 4'd6;
    localparam logic [3:0] ST_MIX_C     = 4'd7;
    localparam logic [3:0] ST_SEED_FIX  = 4'd8;
    localparam logic [3:0] ST_SEED_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       init_reg, init_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        init_next   = init_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd.op      = DP_NOP;
        cmd.idx     = idx_reg;
        s_ready     = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.op     = DP_SEED_ONE;
                idx_next   = 2'd0;
                init_next  = 1'b1;
                state_next = ST_MIX_A;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type) begin
                        cmd.op     = DP_SEED_LOAD;
                        idx_next   = 2'd0;
                        init_next  = 1'b0;
                        state_next = ST_MIX_A;
                    end else begin
                        cmd.op     = DP_GEN_START;
                        state_next = ST_GEN_WAIT1;
                    end
                end
            end
            ST_GEN_WAIT1: begin
                if (stat.mul_done) begin
                    cmd.op     = DP_GEN_SCRAMBLE;
                    state_next = ST_GEN_WAIT2;
                end
            end
            ST_GEN_WAIT2: begin
                if (stat.mul_done) begin
                    state_next = ST_GEN_OUT;
                end
            end
            ST_GEN_OUT: begin
                if (out_free) begin
                    cmd.op      = DP_OUT_GEN;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MIX_A: begin
                cmd.op     = DP_MIX_START;
                state_next = ST_MIX_B;
            end
            ST_MIX_B: begin
                if (stat.mul_done) begin
                    cmd.op     = DP_MIX_MID;
                    state_next = ST_MIX_C;
                end
            end
            ST_MIX_C: begin
                if (stat.mul_done) begin
                    cmd.op     = DP_MIX_END;
                    idx_next   = idx_reg + 2'd1;
                    state_next = (idx_reg == 2'd3) ? ST_SEED_FIX : ST_MIX_A;
                end
            end
            ST_SEED_FIX: begin
                cmd.op     = DP_SEED_FIX;
                state_next = init_reg ? ST_IDLE : ST_SEED_OUT;
            end
            ST_SEED_OUT: begin
                if (out_free) begin
                    cmd.op      = DP_OUT_ZERO;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            idx_reg    <= 2'd0;
            init_reg   <= 1'b1;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            init_reg   <= init_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

endmodule

### rtl/core/xo256ss_checker.sv
// ----------------------------------------------------------------------------
// xo256ss_checker
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xo256ss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_random_value,
    input logic [63:0] m_generated_count
);

    logic [127:0] out_data;

    assign out_data = {m_random_value, m_generated_count};

    // nothing is offered right after reset
    `ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "m_valid high after reset")

    // one item in flight: an accepted transfer drops ready
    `ASSERT_CLK(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready held after accept")

    // a new result only comes out of a busy phase
    `ASSERT_CLK(a_result_from_work, $rose(m_valid) |-> !$past(s_ready), "result without work")

    // stalled result holds
    `ASSERT_CLK(a_out_hold_valid, m_valid && !m_ready |=> m_valid, "stalled result dropped")
    `ASSERT_CLK(a_out_hold_data, m_valid && !m_ready |=> $stable(out_data), "held result changed")

endmodule

bind xoshiro256ss_generator_unit xo256ss_checker u_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_random_value    (m_random_value),
    .m_generated_count (m_generated_count)
);
